// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checking paused while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, checking paused while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// what must hold in the cycle after reset was seen
`define ASSERT_AFTER_RST(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/itf_pkg.sv -----
// shared types, constants and a helper function of the integer to text formatter
package itf_pkg;

  // width of the integer that the conversion works on
  localparam int VALUE_BITS  = 64;
  localparam int NARROW_BITS = 32;

  // port widths
  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 8;

  // operation codes
  localparam logic [1:0] OP_UNSIGNED = 2'd0;
  localparam logic [1:0] OP_SIGNED   = 2'd1;
  localparam logic [1:0] OP_HEX      = 2'd2;

  // work kinds handed from front to back
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_RADIX = 2'd1;
  localparam logic [1:0] KIND_HEX   = 2'd2;

  // digit divider: bits of the dividend handled per cycle
  localparam int DIV_STEP_BITS = 8;
  localparam int DIV_CYC       = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int DVD_W         = DIV_CYC * DIV_STEP_BITS;
  localparam int STEP_W        = $clog2(DIV_CYC);

  // digit stack depth and count width
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  // hex nibbles of the value
  localparam int NIB   = (VALUE_BITS + 3) / 4;
  localparam int NIB_W = $clog2(NIB);

  // queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef logic [NIB-1:0][3:0] nib_vec_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [4:0]            radix;
    logic [4:0]            pad;
  } item_t;

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = CH_ZERO + {4'b0, n};
    end else begin
      c = CH_UPPER + {4'b0, n} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- rtl/itf_front.sv -----
// front end: unpacks an input transaction, masks, negates and classifies it
module itf_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [itf_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [itf_pkg::S_TUSER_W-1:0]  s_tuser,
  input  logic                           q_full,
  output logic                           push,
  output itf_pkg::item_t                 item
);
  import itf_pkg::*;

  localparam logic [VALUE_BITS-1:0] NARROW_MASK = VALUE_BITS'({NARROW_BITS{1'b1}});

  logic [1:0]            opcode;
  logic                  wide;
  logic [4:0]            radix;
  logic [4:0]            pad;
  logic [VALUE_BITS-1:0] mask;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] v_neg;
  logic                  sign;

  assign opcode = s_tuser[1:0];
  assign wide   = s_tuser[2];
  assign radix  = s_tdata[68:64];
  assign pad    = s_tdata[73:69];

  assign mask  = wide ? {VALUE_BITS{1'b1}} : NARROW_MASK;
  assign v     = s_tdata[VALUE_BITS-1:0] & mask;
  assign v_neg = (~v + VALUE_BITS'(1)) & mask;
  assign sign  = wide ? v[VALUE_BITS-1] : v[NARROW_BITS-1];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    item       = '0;
    item.mag   = v;
    item.radix = radix;
    item.pad   = pad;
    case (opcode)
      OP_UNSIGNED: begin
        item.kind = (radix < 5'd2 || radix > 5'd16) ? KIND_EMPTY : KIND_RADIX;
      end
      OP_SIGNED: begin
        item.kind  = KIND_RADIX;
        item.radix = 5'd10;
        item.neg   = sign;
        item.mag   = sign ? v_neg : v;
      end
      OP_HEX: begin
        item.kind = KIND_HEX;
      end
      default: begin
        item.kind = KIND_EMPTY;
      end
    endcase
  end

endmodule

// ----- rtl/itf_queue.sv -----
// small queue of classified work items between front and back
module itf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itf_pkg::item_t item_in,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output itf_pkg::item_t item_out
);
  import itf_pkg::*;

  item_t            entries [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QP_W:0]    count;

  assign full     = (count == (QP_W + 1)'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign item_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QP_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QP_W + 1)'(1);
        2'b01:   count <= count - (QP_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/itf_back.sv -----
// back end: digit divider, digit stack and character sequencer with output register
module itf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  itf_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [itf_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast,
  output logic                          m_tuser
);
  import itf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SIGN  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_HEX0  = 3'd4;
  localparam logic [2:0] S_HEXX  = 3'd5;
  localparam logic [2:0] S_HEXD  = 3'd6;
  localparam logic [2:0] S_EMPTY = 3'd7;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_CYC - 1);

  logic [2:0]       state;
  logic [DVD_W-1:0] dv;
  logic [DVD_W-1:0] dv_next;
  logic [3:0]       rem;
  logic [3:0]       div_rem;
  logic [DIV_STEP_BITS-1:0] div_q;
  logic [STEP_W-1:0] step;
  logic [4:0]       base;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [3:0]       stk [VALUE_BITS];
  nib_vec_t         hv;
  logic [4:0]       pad;
  logic [4:0]       dig;
  logic [3:0]       nib_sel;
  logic             out_free;
  logic             out_load;
  logic             push_dig;
  logic             pop_dig;
  logic             quot_zero;

  // one radix step per dividend bit, a byte of the dividend per cycle
  always_comb begin
    logic [DIV_STEP_BITS-1:0] chunk;
    logic [3:0]               rr;
    logic [4:0]               r2;
    chunk = dv[DVD_W-1 -: DIV_STEP_BITS];
    rr    = rem;
    div_q = '0;
    for (int i = DIV_STEP_BITS - 1; i >= 0; i--) begin
      r2 = {rr, chunk[i]};
      if (r2 >= base) begin
        r2       = r2 - base;
        div_q[i] = 1'b1;
      end
      rr = r2[3:0];
    end
    div_rem = rr;
  end

  assign dv_next   = {dv[DVD_W-DIV_STEP_BITS-1:0], div_q};
  assign quot_zero = (dv_next == '0);

  assign nib_sel  = ({1'b0, dig[3:0]} < 5'(NIB) && dig < 5'(NIB)) ? hv[dig[NIB_W-1:0]] : 4'd0;
  assign out_free = !m_tvalid || m_tready;
  // every state but idle and divide loads one character when the register frees up
  assign out_load = out_free && (state != S_IDLE) && (state != S_DIV);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign push_dig = (state == S_DIV) && (step == STEP_LAST);
  assign pop_dig  = (state == S_EMIT) && out_free;

  // digit stack, least significant digit pushed first
  always_ff @(posedge clk) begin
    if (push_dig) begin
      stk[0] <= div_rem;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (pop_dig) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dv   <= DVD_W'(q_item.mag);
      hv   <= nib_vec_t'((NIB * 4)'(q_item.mag));
      base <= q_item.radix;
      neg  <= q_item.neg;
      pad  <= q_item.pad;
    end else if (state == S_DIV) begin
      dv <= dv_next;
    end
  end

  // output valid: set on a load, cleared once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tdata  <= CH_NUL;
      m_tlast  <= 1'b0;
      m_tuser  <= 1'b0;
      rem      <= '0;
      step     <= '0;
      cnt      <= '0;
      dig      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            rem  <= '0;
            step <= '0;
            cnt  <= '0;
            case (q_item.kind)
              KIND_RADIX: state <= S_DIV;
              KIND_HEX:   state <= S_HEX0;
              default:    state <= S_EMPTY;
            endcase
          end
        end
        S_DIV: begin
          if (step == STEP_LAST) begin
            step <= '0;
            rem  <= '0;
            cnt  <= cnt + CNT_W'(1);
            if (quot_zero) begin
              state <= neg ? S_SIGN : S_EMIT;
            end
          end else begin
            step <= step + STEP_W'(1);
            rem  <= div_rem;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            m_tdata  <= CH_MINUS;
            m_tlast  <= 1'b0;
            m_tuser  <= 1'b0;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tdata  <= digit_char(stk[0]);
            m_tlast  <= (cnt == CNT_W'(1));
            m_tuser  <= 1'b0;
            cnt      <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_HEX0: begin
          if (out_free) begin
            m_tdata  <= CH_ZERO;
            m_tlast  <= 1'b0;
            m_tuser  <= 1'b0;
            state    <= S_HEXX;
          end
        end
        S_HEXX: begin
          if (out_free) begin
            m_tdata  <= CH_X;
            m_tlast  <= (pad == 5'd0);
            m_tuser  <= 1'b0;
            dig      <= pad - 5'd1;
            state    <= (pad == 5'd0) ? S_IDLE : S_HEXD;
          end
        end
        S_HEXD: begin
          if (out_free) begin
            m_tdata  <= digit_char(nib_sel);
            m_tlast  <= (dig == 5'd0);
            m_tuser  <= 1'b0;
            dig      <= dig - 5'd1;
            if (dig == 5'd0) begin
              state <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            m_tdata  <= CH_NUL;
            m_tlast  <= 1'b1;
            m_tuser  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/integer_to_text_formatter.sv -----
// top level of the integer to text formatter
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s       | in  | s_tvalid/s_tready  | tdata: value, radix, pad_digits;
//          |     |                    | tuser: opcode, wide
//  m       | out | m_tvalid/m_tready  | tdata: char_code; tlast: last; tuser: empty_res
//
// every item is first taken from the queue by the back end while it is idle
// radix and signed items: one digit per pass of the byte-serial digit divider,
//   then one character at a time from the output register (a sign first, if negative)
// hex items: pad_digits + 2 characters, one per cycle unless the output stalls; invalid items: one empty result
// the two-entry queue lets the front take new transactions while the back works
// reset clears the sequencer, the queue pointers and the output register (valid and data) only
// output stalls hold the character in the output register and the sequencer in its character states
module integer_to_text_formatter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [63:0] value, [68:64] radix, [73:69] pad_digits, [79:74] zero
  input  logic [itf_pkg::S_TDATA_W-1:0]  s_tdata,
  // [1:0] opcode, [2] wide
  input  logic [itf_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] char_code
  output logic [itf_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                           m_tlast,
  // [0] empty_res
  output logic                           m_tuser
);
  import itf_pkg::*;

  // classified work between front and back
  item_t front_item;
  item_t head_item;
  logic  front_push;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  itf_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (front_push),
    .item     (front_item)
  );

  itf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .item_in  (front_item),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .item_out (head_item)
  );

  // divider, digit stack and character sequencer
  itf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (head_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- rtl/itf_checker.sv -----
// port-level checks of the integer to text formatter and their bind
`include "assert_macros.svh"

module itf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [itf_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast,
  input logic                          m_tuser
);
  import itf_pkg::*;

  // no output transaction right after reset
  `ASSERT_AFTER_RST(a_rst_quiet, clk, rst, !m_tvalid)

  // an empty result is always a single, final transaction
  `ASSERT_IMPL(a_empty_last, clk, rst, m_tvalid && m_tuser, m_tlast)

  // an empty result carries a nul character
  `ASSERT_IMPL(a_empty_nul, clk, rst, m_tvalid && m_tuser, m_tdata == CH_NUL)

  // a stalled character stays put
  `ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ----- sim/integer_to_text_formatter_tb.sv -----
// testbench for the integer to text formatter: directed table, then random items

module integer_to_text_formatter_tb;
  import itf_pkg::*;

  // opcode 3 has no package name: the block answers with a single empty result
  localparam logic [1:0] OP_UNDEF = 2'd3;

  // digit glyphs, index 0 in the top byte
  localparam logic [127:0] DIGIT_SET = "0123456789ABCDEF";

  localparam int RANDOM_ITEMS = 480;
  // longest item: 64 binary digits through the byte-serial divider, then output
  localparam int DRAIN_CYCLES = 800;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int REPORT_MAX   = 10;

  // how a directed row gets its expected text
  typedef enum logic [1:0] {ROW_PREDICT, ROW_TEXT, ROW_EMPTY} row_kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic        wide;
    logic [4:0]  radix;
    logic [4:0]  pad;
    row_kind_t   kind;
  } text_row_t;

  // one expected output transaction
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       empty;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  text_char_t  pending_chars[$];
  text_row_t   dir_rows[$];
  string       dir_text[$];
  int          bad_chars = 0;
  int          chars_seen = 0;
  int          burst_left = 0;
  int          cycle_count = 0;

  integer_to_text_formatter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: expected characters of one accepted item
  // ---------------------------------------------------------------------------

  function automatic void push_char(input logic [7:0] code, input logic last,
                                    input logic empty);
    text_char_t c;
    c.code  = code;
    c.last  = last;
    c.empty = empty;
    pending_chars.push_back(c);
  endfunction

  function automatic logic [7:0] glyph(input int n);
    return DIGIT_SET[8*(15-n) +: 8];
  endfunction

  // digits of v in the given base, most significant first, no leading zeros
  function automatic void push_number(input logic [63:0] v, input int base);
    logic [7:0]  rev[$];
    logic [63:0] rest;
    rest = v;
    if (rest == 64'd0) rev.push_back("0");
    while (rest != 64'd0) begin
      rev.push_back(glyph(int'(rest % 64'(base))));
      rest = rest / 64'(base);
    end
    for (int i = rev.size() - 1; i >= 0; i--) push_char(rev[i], i == 0, 1'b0);
  endfunction

  function automatic void predict_text(input logic [1:0] op, input logic [63:0] value,
                                       input logic wide, input logic [4:0] radix,
                                       input logic [4:0] pad);
    logic [63:0] mask;
    logic [63:0] v;
    int          top;
    mask = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    top  = wide ? 63 : 31;
    v    = value & mask;
    case (op)
      OP_UNSIGNED: begin
        if (radix < 5'd2 || radix > 5'd16) begin
          push_char(CH_NUL, 1'b1, 1'b1);
        end else begin
          push_number(v, int'(radix));
        end
      end
      OP_SIGNED: begin
        // negate within the active width so the most negative value prints whole
        if (v[top]) begin
          push_char("-", 1'b0, 1'b0);
          v = (64'd0 - v) & mask;
        end
        push_number(v, 10);
      end
      OP_HEX: begin
        push_char("0", 1'b0, 1'b0);
        push_char("x", pad == 5'd0, 1'b0);
        // digit positions beyond bit 63 read as zero
        for (int d = int'(pad) - 1; d >= 0; d--) begin
          push_char(glyph((d * 4 < 64) ? int'((v >> (d * 4)) & 64'hF) : 0), d == 0, 1'b0);
        end
      end
      default: begin
        push_char(CH_NUL, 1'b1, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------

  task automatic send_item(input logic [1:0] op, input logic [63:0] value,
                           input logic wide, input logic [4:0] radix,
                           input logic [4:0] pad, input row_kind_t kind,
                           input string text);
    if (burst_left == 0) begin
      // idle gap with junk on the data lines
      s_tvalid <= 1'b0;
      s_tdata  <= 80'({$urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, pad, radix, value};
    s_tuser  <= {wide, op};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    // the transaction was taken at this edge: book its expected characters
    case (kind)
      ROW_TEXT: begin
        for (int i = 0; i < text.len(); i++) push_char(text[i], i == text.len() - 1, 1'b0);
      end
      ROW_EMPTY: push_char(CH_NUL, 1'b1, 1'b1);
      default:   predict_text(op, value, wide, radix, pad);
    endcase
  endtask

  function automatic void add_row(input logic [1:0] op, input logic [63:0] value,
                                  input logic wide, input logic [4:0] radix,
                                  input logic [4:0] pad, input row_kind_t kind,
                                  input string text);
    text_row_t r;
    r.op    = op;
    r.value = value;
    r.wide  = wide;
    r.radix = radix;
    r.pad   = pad;
    r.kind  = kind;
    dir_rows.push_back(r);
    dir_text.push_back(text);
  endfunction

  // value mix: extremes, small numbers, short and full random patterns
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0:       v = 64'd0;
      1:       v = 64'hFFFF_FFFF_FFFF_FFFF;
      2:       v = 64'h8000_0000_0000_0000;
      3:       v = {$urandom, 32'h8000_0000};
      4:       v = 64'($urandom_range(0, 1000));
      5:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    logic [1:0]  op;
    logic [4:0]  radix;
    logic [4:0]  pad;
    int          pick;

    // zero, every invalid radix class, undefined opcode
    add_row(OP_UNSIGNED, 64'd0, 1'b0, 5'd10, 5'd0, ROW_TEXT, "0");
    add_row(OP_UNSIGNED, 64'd5, 1'b0, 5'd0, 5'd0, ROW_EMPTY, "");
    add_row(OP_UNSIGNED, 64'd5, 1'b1, 5'd1, 5'd0, ROW_EMPTY, "");
    add_row(OP_UNSIGNED, 64'd5, 1'b0, 5'd17, 5'd0, ROW_EMPTY, "");
    add_row(OP_UNSIGNED, 64'd5, 1'b1, 5'd31, 5'd31, ROW_EMPTY, "");
    add_row(OP_UNDEF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd31, 5'd31, ROW_EMPTY, "");
    add_row(OP_UNDEF, 64'd0, 1'b0, 5'd10, 5'd4, ROW_EMPTY, "");
    // unsigned extremes in every base edge
    add_row(OP_UNSIGNED, 64'd1, 1'b0, 5'd2, 5'd0, ROW_TEXT, "1");
    add_row(OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd2, 5'd0, ROW_PREDICT, "");
    add_row(OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd16, 5'd0, ROW_TEXT, "FFFFFFFF");
    add_row(OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd16, 5'd0, ROW_TEXT,
            "FFFFFFFFFFFFFFFF");
    add_row(OP_UNSIGNED, 64'hFFFF_FFFF_0000_0000, 1'b0, 5'd10, 5'd0, ROW_TEXT, "0");
    add_row(OP_UNSIGNED, 64'hDEAD_BEEF_1234_5678, 1'b1, 5'd7, 5'd0, ROW_PREDICT, "");
    // signed: most negative, all ones, largest positive, zero, junk above bit 31
    add_row(OP_SIGNED, 64'h0000_0000_8000_0000, 1'b0, 5'd0, 5'd0, ROW_TEXT, "-2147483648");
    add_row(OP_SIGNED, 64'h8000_0000_0000_0000, 1'b1, 5'd0, 5'd0, ROW_TEXT,
            "-9223372036854775808");
    add_row(OP_SIGNED, 64'd0, 1'b1, 5'd31, 5'd31, ROW_TEXT, "0");
    add_row(OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd0, 5'd0, ROW_TEXT, "-1");
    add_row(OP_SIGNED, 64'h0000_0000_7FFF_FFFF, 1'b0, 5'd0, 5'd0, ROW_TEXT, "2147483647");
    add_row(OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd0, 5'd0, ROW_TEXT,
            "9223372036854775807");
    add_row(OP_SIGNED, 64'h1234_5678_FFFF_FFFE, 1'b0, 5'd0, 5'd0, ROW_TEXT, "-2");
    // hex: zero padding, full width, narrow value padded, padding past 64 bits
    add_row(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd0, 5'd0, ROW_TEXT, "0x");
    add_row(OP_HEX, 64'h0123_4567_89AB_CDEF, 1'b1, 5'd0, 5'd16, ROW_TEXT,
            "0x0123456789ABCDEF");
    add_row(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 5'd0, 5'd16, ROW_TEXT,
            "0x00000000FFFFFFFF");
    add_row(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd0, 5'd31, ROW_PREDICT, "");
    add_row(OP_HEX, 64'hA5A5_5A5A_C3C3_3C3C, 1'b0, 5'd31, 5'd3, ROW_PREDICT, "");

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].wide, dir_rows[i].radix,
                dir_rows[i].pad, dir_rows[i].kind, dir_text[i]);
    end

    // random part: mostly well-formed items, a few invalid radices and opcode 3
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      op   = (pick < 40) ? OP_UNSIGNED : (pick < 70) ? OP_SIGNED :
             (pick < 95) ? OP_HEX : OP_UNDEF;
      radix = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(2, 16))
                                          : 5'($urandom_range(0, 31));
      pad   = ($urandom_range(0, 6) != 0) ? 5'($urandom_range(0, 16))
                                          : 5'($urandom_range(0, 31));
      send_item(op, pick_value(), 1'($urandom), radix, pad, ROW_PREDICT, "");
    end
    s_tvalid <= 1'b0;

    // drain, then give a late extra character time to show up
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (bad_chars == 0 && pending_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: stall modes that change at random
  // ---------------------------------------------------------------------------

  int         rdy_mode = 0;
  int         rdy_left = 0;
  logic [7:0] rdy_pattern = 8'h01;

  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode    <= $urandom_range(0, 2);
      rdy_left    <= $urandom_range(32, 256);
      rdy_pattern <= 8'($urandom) | 8'h01;
      m_tready    <= 1'b0;
    end else begin
      rdy_left <= rdy_left - 1;
      case (rdy_mode)
        0: m_tready <= 1'b1;
        1: begin
          // rotating pattern that always holds a ready bit, so a stall never lasts a whole turn
          m_tready    <= rdy_pattern[0];
          rdy_pattern <= {rdy_pattern[0], rdy_pattern[7:1]};
        end
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every output transaction against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        bad_chars++;
        if (bad_chars <= REPORT_MAX)
          $display("char %0d: none expected, got %h last %0b empty %0b",
                   chars_seen, m_tdata, m_tlast, m_tuser);
      end else begin
        want = pending_chars.pop_front();
        if (m_tdata !== want.code || m_tlast !== want.last || m_tuser !== want.empty) begin
          bad_chars++;
          if (bad_chars <= REPORT_MAX)
            $display("char %0d: expected %h last %0b empty %0b, got %h last %0b empty %0b",
                     chars_seen, want.code, want.last, want.empty,
                     m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/itf_pkg.sv
rtl/itf_front.sv
rtl/itf_queue.sv
rtl/itf_back.sv
rtl/integer_to_text_formatter.sv
rtl/itf_checker.sv
sim/integer_to_text_formatter_tb.sv
